// ===== rtl/core/lsbm_pkg.sv =====
// Shared types and constants for the RV32 load/store byte memory.
// Used by the address decoder, the top level and the port checker.
// Depends on nothing.
package lsbm_pkg;

    localparam int unsigned DEFAULT_RAM_SIZE = 65536;
    localparam int unsigned NUM_BANKS        = 4;

    localparam logic [31:0] DEBUG_ADDR_RESET = 32'hFFFF_FFFF;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // Access size codes, width_code[1:0].
    localparam logic [1:0] LSZ_BYTE = 2'b00;
    localparam logic [1:0] LSZ_HALF = 2'b01;
    localparam logic [1:0] LSZ_WORD = 2'b10;
    localparam logic [1:0] LSZ_BAD  = 2'b11;

    // Largest width code that a store may use.
    localparam logic [2:0] FUNC3_STORE_MAX = 3'b010;

    localparam logic [7:0] NEWLINE = 8'h0A;

    // Per-access control produced by the decoder.
    typedef struct packed {
        logic                 fault;
        logic                 dbg_valid;
        logic [7:0]           dbg_byte;
        logic                 dbg_line_end;
        logic [NUM_BANKS-1:0] bank_rd;
        logic [NUM_BANKS-1:0] bank_wr;
    } lsbm_ctrl_t;

endpackage

// ===== rtl/core/lsbm_bank.sv =====
// One byte-wide bank of the data memory, synchronous read and write.
// Uses no package items.
module lsbm_bank #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned ROW_W = 14
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[row] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lsbm_decode.sv =====
// Address decoder: splits an access into per-bank rows and enables,
// checks for faults and picks out a byte aimed at the debug address.
// Depends on lsbm_pkg.
module lsbm_decode #(
    parameter int unsigned RAM_SIZE = lsbm_pkg::DEFAULT_RAM_SIZE,
    parameter int unsigned ROW_W    = 14
) (
    input  logic                    command,
    input  logic [31:0]             address,
    input  logic [2:0]              width_code,
    input  logic [31:0]             store_data,
    input  logic [31:0]             debug_address,
    output lsbm_pkg::lsbm_ctrl_t    ctrl,
    output logic [ROW_W-1:0]        row   [lsbm_pkg::NUM_BANKS],
    output logic [7:0]              wdata [lsbm_pkg::NUM_BANKS]
);

    localparam logic [32:0] RAM_LIMIT = 33'(RAM_SIZE);
    localparam int unsigned NB        = lsbm_pkg::NUM_BANKS;

    logic [31:0]   byte_addr [NB];
    logic [NB-1:0] byte_en;
    logic [NB-1:0] hit_dbg;
    logic [NB-1:0] outside;
    logic          is_store;
    logic          bad_code;
    logic          fault;
    logic [7:0]    dbg_byte;

    always_comb
    begin
        is_store = (command == lsbm_pkg::CMD_STORE);
        bad_code = (width_code[1:0] == lsbm_pkg::LSZ_BAD) ||
                   (is_store && (width_code > lsbm_pkg::FUNC3_STORE_MAX));
        dbg_byte = 8'h00;
        for (int i = 0; i < NB; i++)
        begin
            byte_addr[i] = address + 32'(i);
            if (i == 0)
            begin
                byte_en[i] = 1'b1;
            end
            else if (i == 1)
            begin
                byte_en[i] = (width_code[1:0] != lsbm_pkg::LSZ_BYTE);
            end
            else
            begin
                byte_en[i] = width_code[1];
            end
            hit_dbg[i] = is_store && byte_en[i] && (byte_addr[i] == debug_address);
            outside[i] = byte_en[i] && !hit_dbg[i] && ({1'b0, byte_addr[i]} >= RAM_LIMIT);
            if (hit_dbg[i])
            begin
                dbg_byte = store_data[8*i +: 8];
            end
        end
        fault = bad_code || (|outside);
    end

    // Bank k holds the bytes whose address is k modulo four; the byte of the
    // access that lands there is number (k - address) modulo four.
    always_comb
    begin
        logic [1:0] j;
        ctrl.fault        = fault;
        ctrl.dbg_valid    = !fault && (|hit_dbg);
        ctrl.dbg_byte     = ctrl.dbg_valid ? dbg_byte : 8'h00;
        ctrl.dbg_line_end = ctrl.dbg_valid && (dbg_byte == lsbm_pkg::NEWLINE);
        for (int k = 0; k < NB; k++)
        begin
            j = 2'(k) - address[1:0];
            row[k]        = byte_addr[j][ROW_W+1:2];
            wdata[k]      = store_data[8*j +: 8];
            ctrl.bank_rd[k] = !fault && !is_store && byte_en[j];
            ctrl.bank_wr[k] = !fault && is_store && byte_en[j] && !hit_dbg[j];
        end
    end

endmodule

// ===== rtl/core/riscv_load_store_byte_memory.sv =====
// Top level of the RV32 load/store byte memory: four byte banks, the
// address decoder and the result stage.
// Depends on lsbm_pkg, lsbm_decode and lsbm_bank.
//
//  channel   signals                                        direction  handshake
//  --------  ---------------------------------------------  ---------  ---------------------
//  command   start, command, address, width_code,           in         start && !busy
//            store_data, busy
//  result    done, load_data, access_fault, debug_valid,    out        done, one cycle only
//            debug_byte, debug_line_end
//  config    cfg_valid, cfg_data, cfg_ready                 in         cfg_valid && cfg_ready
//
// Every access passes through the banks: the word is accepted at a
// clock edge and its result is shown on the cycle after, marked by done. The
// read of the bank memories is registered. A new word can
// be accepted at every edge, so busy never rises; a store is written at its
// accept edge, so a load in the next word already sees it.
// Reset clears the control state and sets the debug address to all ones.
// The memory contents are undefined after reset and are not cleared.
// The receiver cannot stall: a result is on the ports for one cycle only.
module riscv_load_store_byte_memory #(
    parameter int unsigned RAM_SIZE = lsbm_pkg::DEFAULT_RAM_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] address,
    input  logic [2:0]  width_code,
    input  logic [31:0] store_data,

    output logic        done,
    output logic [31:0] load_data,
    output logic        access_fault,
    output logic        debug_valid,
    output logic [7:0]  debug_byte,
    output logic        debug_line_end,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int unsigned NB         = lsbm_pkg::NUM_BANKS;
    localparam int unsigned BANK_DEPTH = (RAM_SIZE + NB - 1) / NB;
    localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic                 accept;
    lsbm_pkg::lsbm_ctrl_t ctrl;
    logic [ROW_W-1:0]     row      [NB];
    logic [7:0]           wdata    [NB];
    logic [7:0]           rd_data  [NB];

    logic [31:0] debug_address_reg;
    logic        done_reg;
    logic        cmd_reg;
    logic [1:0]  lsz_reg;
    logic        uns_reg;
    logic [1:0]  offs_reg;
    logic        fault_reg;
    logic        dbg_valid_reg;
    logic [7:0]  dbg_byte_reg;
    logic        dbg_end_reg;

    logic [31:0] raw;
    logic        sgn;

    // The block takes a word every cycle; the handshake is kept for the user.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debug_address_reg <= lsbm_pkg::DEBUG_ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debug_address_reg <= cfg_data;
        end
    end

    lsbm_decode #(
        .RAM_SIZE (RAM_SIZE),
        .ROW_W    (ROW_W)
    ) u_decode (
        .command       (command),
        .address       (address),
        .width_code    (width_code),
        .store_data    (store_data),
        .debug_address (debug_address_reg),
        .ctrl          (ctrl),
        .row           (row),
        .wdata         (wdata)
    );

    // Bank k holds every byte whose address is k modulo four, so a misaligned
    // access still touches each bank at most once.
    for (genvar k = 0; k < NB; k++)
    begin : g_bank
        lsbm_bank #(
            .DEPTH (BANK_DEPTH),
            .ROW_W (ROW_W)
        ) u_bank (
            .clk   (clk),
            .we    (accept && ctrl.bank_wr[k]),
            .re    (accept && ctrl.bank_rd[k]),
            .row   (row[k]),
            .wdata (wdata[k]),
            .rdata (rd_data[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Everything the result stage needs to rebuild the loaded word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= command;
            lsz_reg       <= width_code[1:0];
            uns_reg       <= width_code[2];
            offs_reg      <= address[1:0];
            fault_reg     <= ctrl.fault;
            dbg_valid_reg <= ctrl.dbg_valid;
            dbg_byte_reg  <= ctrl.dbg_byte;
            dbg_end_reg   <= ctrl.dbg_line_end;
        end
    end

    // Rotate the bank outputs back into byte order, then extend. Bytes above
    // the access size come from banks that were not read and are dropped.
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            raw[8*i +: 8] = rd_data[2'(offs_reg + 2'(i))];
        end
        sgn = !uns_reg;
        if (fault_reg || (cmd_reg == lsbm_pkg::CMD_STORE))
        begin
            load_data = 32'h0000_0000;
        end
        else
        begin
            unique case (lsz_reg)
                lsbm_pkg::LSZ_BYTE: load_data = {{24{sgn && raw[7]}}, raw[7:0]};
                lsbm_pkg::LSZ_HALF: load_data = {{16{sgn && raw[15]}}, raw[15:0]};
                default:            load_data = raw;
            endcase
        end
    end

    assign done           = done_reg;
    assign access_fault   = fault_reg;
    assign debug_valid    = dbg_valid_reg;
    assign debug_byte     = dbg_byte_reg;
    assign debug_line_end = dbg_end_reg;

endmodule

// ===== rtl/core/lsbm_checker.sv =====
// Port-level checker for the RV32 load/store byte memory, with its bind.
// Depends on lsbm_pkg and the top level riscv_load_store_byte_memory.
module lsbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        command,
    input logic [2:0]  width_code,
    input logic        done,
    input logic [31:0] load_data,
    input logic        access_fault,
    input logic        debug_valid,
    input logic [7:0]  debug_byte,
    input logic        debug_line_end
);

    // Each accepted word gives exactly one result, in the cycle after it is accepted.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (done == $past(start && !busy)))
        else $error("result strobe does not follow the accepted word");

    // A refused access returns nothing but the fault flag.
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_fault) |-> ((load_data == 32'h0) && !debug_valid))
        else $error("faulted access carries data or a debug character");

    // Debug characters only come from stores, which return no data.
    a_debug_store: assert property (@(posedge clk) disable iff (!rst_n)
        (done && debug_valid) |-> (($past(command) == lsbm_pkg::CMD_STORE) &&
                                   (load_data == 32'h0)))
        else $error("debug character without a store");

    // The line end flag matches the character.
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (done && debug_line_end) |-> (debug_valid && (debug_byte == lsbm_pkg::NEWLINE)))
        else $error("line end flag without a newline character");

    // The reserved size code always faults.
    a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(width_code[1:0]) == lsbm_pkg::LSZ_BAD)) |-> access_fault)
        else $error("reserved access size did not fault");

endmodule

bind riscv_load_store_byte_memory lsbm_checker u_lsbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .width_code     (width_code),
    .done           (done),
    .load_data      (load_data),
    .access_fault   (access_fault),
    .debug_valid    (debug_valid),
    .debug_byte     (debug_byte),
    .debug_line_end (debug_line_end)
);
